@@ design/dfb_pkg.sv @@
// Shared types and constants of the dual FIFO serial frame bridge.
package dfb_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_GPIO   = 2'd1,
    OP_FRAME  = 2'd2,
    OP_REPORT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_REPORT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic [1:0] Q_OUT0 = 2'd0;
  localparam logic [1:0] Q_OUT1 = 2'd1;
  localparam logic [1:0] Q_IN0  = 2'd2;
  localparam logic [1:0] Q_IN1  = 2'd3;

  localparam logic [7:0] GPIO_IN_RESET = 8'hAA;

endpackage

@@ design/dfb_req_if.sv @@
// Request channel of the bridge: one host operation per item.
interface dfb_req_if;
  logic            valid;
  logic            ready;
  dfb_pkg::op_t    operation;
  logic            channel;
  logic [7:0]      data;
  logic [7:0]      rx_status;
  logic [7:0]      rx_chan0;
  logic [7:0]      rx_chan1;
  logic            hold;

  modport source (
    output valid, operation, channel, data, rx_status, rx_chan0, rx_chan1, hold,
    input  ready
  );
  modport sink (
    input  valid, operation, channel, data, rx_status, rx_chan0, rx_chan1, hold,
    output ready
  );
endinterface

@@ design/dfb_rsp_if.sv @@
// Result channel of the bridge: one result per item, or a run of bytes ended by last for a report.
interface dfb_rsp_if;
  logic            valid;
  logic            ready;
  dfb_pkg::kind_t  kind;
  logic            accepted;
  logic [7:0]      tx_status;
  logic [7:0]      tx_chan0;
  logic [7:0]      tx_chan1;
  logic [7:0]      report_byte;
  logic            last;

  modport source (
    output valid, kind, accepted, tx_status, tx_chan0, tx_chan1, report_byte, last,
    input  ready
  );
  modport sink (
    input  valid, kind, accepted, tx_status, tx_chan0, tx_chan1, report_byte, last,
    output ready
  );
endinterface

@@ design/dfb_mem.sv @@
// Byte memory that holds all four queues, one write and one registered read port.
module dfb_mem #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/dfb_seq.sv @@
// Sequencer: queue pointers, gpio registers, operation control and the result register.
module dfb_seq #(
  parameter int QUEUE_DEPTH = 16,
  localparam int IW = $clog2(QUEUE_DEPTH),
  localparam int AW = IW + 2,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  dfb_req_if.sink       req,
  dfb_rsp_if.source     rsp,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output logic [7:0]    mem_wr_data,
  output logic          mem_rd_en,
  output logic [AW-1:0] mem_rd_addr,
  input  logic [7:0]    mem_rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FRAME_A,
    S_FRAME_B,
    S_REP_HDR,
    S_REP_RD,
    S_REP_DATA
  } state_t;

  state_t         state;
  dfb_pkg::op_t   item_op;
  logic           item_chan;
  logic [7:0]     item_data;
  logic [7:0]     item_rxs;
  logic [7:0]     item_rx0;
  logic [7:0]     item_rx1;
  logic           item_hold;

  logic [IW-1:0]  wr_ptr [4];
  logic [IW-1:0]  rd_ptr [4];
  logic [CW-1:0]  count  [4];
  logic [5:0]     gpio_tx;
  logic [7:0]     gpio_in;

  logic           frame_v0;
  logic [7:0]     frame_b0;
  logic [1:0]     hdr_idx;
  logic           rep_last;

  logic           out_valid;
  dfb_pkg::kind_t out_kind;
  logic           out_accepted;
  logic [7:0]     out_status;
  logic [7:0]     out_chan0;
  logic [7:0]     out_chan1;
  logic [7:0]     out_report;
  logic           out_last;

  logic           out_free;
  logic           in_full;
  logic           push_ok;
  logic           push_go;
  logic [1:0]     push_q;
  logic           pop_go;
  logic [1:0]     pop_q;
  logic [1:0]     rd_q;
  logic [1:0]     rep_q;
  logic [CW:0]    in_total;
  logic           in_empty;
  logic [8:0]     cnt0_wide;
  logic [8:0]     cnt1_wide;
  logic [7:0]     cnt0_sat;
  logic [7:0]     cnt1_sat;

  function automatic logic [IW-1:0] next_ptr(input logic [IW-1:0] p);
    return (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + IW'(1);
  endfunction

  assign out_free  = !out_valid || rsp.ready;
  assign in_full   = (count[dfb_pkg::Q_IN0] == CW'(QUEUE_DEPTH)) ||
                     (count[dfb_pkg::Q_IN1] == CW'(QUEUE_DEPTH));
  assign push_ok   = (count[{1'b0, item_chan}] != CW'(QUEUE_DEPTH));
  assign in_total  = (CW + 1)'(count[dfb_pkg::Q_IN0]) + (CW + 1)'(count[dfb_pkg::Q_IN1]);
  assign in_empty  = (in_total == '0);
  assign rep_q     = (count[dfb_pkg::Q_IN0] != '0) ? dfb_pkg::Q_IN0 : dfb_pkg::Q_IN1;
  assign cnt0_wide = 9'(count[dfb_pkg::Q_IN0]);
  assign cnt1_wide = 9'(count[dfb_pkg::Q_IN1]);
  assign cnt0_sat  = cnt0_wide[8] ? 8'hFF : cnt0_wide[7:0];
  assign cnt1_sat  = cnt1_wide[8] ? 8'hFF : cnt1_wide[7:0];

  always_comb begin
    push_go     = 1'b0;
    push_q      = {1'b0, item_chan};
    mem_wr_data = item_data;
    pop_go      = 1'b0;
    pop_q       = dfb_pkg::Q_OUT0;
    mem_rd_en   = 1'b0;
    rd_q        = dfb_pkg::Q_OUT0;
    case (state)
      S_EXEC: begin
        if (item_op == dfb_pkg::OP_PUSH) begin
          push_go = out_free && push_ok;
        end else if (item_op == dfb_pkg::OP_FRAME && !item_hold && !in_full) begin
          push_go     = item_rxs[0];
          push_q      = dfb_pkg::Q_IN0;
          mem_wr_data = item_rx0;
          mem_rd_en   = 1'b1;
          rd_q        = dfb_pkg::Q_OUT0;
        end
      end
      S_FRAME_A: begin
        push_go     = item_rxs[1];
        push_q      = dfb_pkg::Q_IN1;
        mem_wr_data = item_rx1;
        pop_go      = (count[dfb_pkg::Q_OUT0] != '0);
        pop_q       = dfb_pkg::Q_OUT0;
        mem_rd_en   = 1'b1;
        rd_q        = dfb_pkg::Q_OUT1;
      end
      S_FRAME_B: begin
        pop_go = out_free && (count[dfb_pkg::Q_OUT1] != '0);
        pop_q  = dfb_pkg::Q_OUT1;
      end
      S_REP_RD: begin
        pop_go    = 1'b1;
        pop_q     = rep_q;
        mem_rd_en = 1'b1;
        rd_q      = rep_q;
      end
      default: begin
      end
    endcase
  end

  assign mem_wr_en   = push_go;
  assign mem_wr_addr = {push_q, wr_ptr[push_q]};
  assign mem_rd_addr = {rd_q, rd_ptr[rd_q]};

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.accepted    = out_accepted;
  assign rsp.tx_status   = out_status;
  assign rsp.tx_chan0    = out_chan0;
  assign rsp.tx_chan1    = out_chan1;
  assign rsp.report_byte = out_report;
  assign rsp.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      gpio_tx   <= '0;
      gpio_in   <= dfb_pkg::GPIO_IN_RESET;
      for (int i = 0; i < 4; i++) begin
        wr_ptr[i] <= '0;
        rd_ptr[i] <= '0;
        count[i]  <= '0;
      end
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (push_go) begin
        wr_ptr[push_q] <= next_ptr(wr_ptr[push_q]);
        count[push_q]  <= count[push_q] + CW'(1);
      end
      if (pop_go) begin
        rd_ptr[pop_q] <= next_ptr(rd_ptr[pop_q]);
        count[pop_q]  <= count[pop_q] - CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            item_op   <= req.operation;
            item_chan <= req.channel;
            item_data <= req.data;
            item_rxs  <= req.rx_status;
            item_rx0  <= req.rx_chan0;
            item_rx1  <= req.rx_chan1;
            item_hold <= req.hold;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (item_op == dfb_pkg::OP_PUSH || item_op == dfb_pkg::OP_GPIO) begin
            if (out_free) begin
              out_valid    <= 1'b1;
              out_kind     <= dfb_pkg::KIND_ACK;
              out_accepted <= (item_op == dfb_pkg::OP_GPIO) || push_ok;
              out_status   <= '0;
              out_chan0    <= '0;
              out_chan1    <= '0;
              out_report   <= '0;
              out_last     <= 1'b1;
              if (item_op == dfb_pkg::OP_GPIO) begin
                gpio_tx <= item_data[5:0];
              end
              state <= S_IDLE;
            end
          end else if (item_hold || (item_op == dfb_pkg::OP_FRAME && in_full)) begin
            if (out_free) begin
              out_valid    <= 1'b1;
              out_kind     <= dfb_pkg::KIND_NONE;
              out_accepted <= 1'b0;
              out_status   <= '0;
              out_chan0    <= '0;
              out_chan1    <= '0;
              out_report   <= '0;
              out_last     <= 1'b1;
              state        <= S_IDLE;
            end
          end else if (item_op == dfb_pkg::OP_FRAME) begin
            state <= S_FRAME_A;
          end else begin
            hdr_idx <= '0;
            state   <= S_REP_HDR;
          end
        end
        S_FRAME_A: begin
          frame_v0 <= (count[dfb_pkg::Q_OUT0] != '0);
          frame_b0 <= (count[dfb_pkg::Q_OUT0] != '0) ? mem_rd_data : 8'h00;
          state    <= S_FRAME_B;
        end
        S_FRAME_B: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_kind     <= dfb_pkg::KIND_FRAME;
            out_accepted <= 1'b0;
            out_status   <= {gpio_tx, (count[dfb_pkg::Q_OUT1] != '0), frame_v0};
            out_chan0    <= frame_b0;
            out_chan1    <= (count[dfb_pkg::Q_OUT1] != '0) ? mem_rd_data : 8'h00;
            out_report   <= '0;
            out_last     <= 1'b1;
            gpio_in      <= {2'b00, item_rxs[7:2]};
            state        <= S_IDLE;
          end
        end
        S_REP_HDR: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_kind     <= dfb_pkg::KIND_REPORT;
            out_accepted <= 1'b0;
            out_status   <= '0;
            out_chan0    <= '0;
            out_chan1    <= '0;
            out_last     <= (hdr_idx == 2'd2) && in_empty;
            case (hdr_idx)
              2'd0:    out_report <= gpio_in;
              2'd1:    out_report <= cnt0_sat;
              default: out_report <= cnt1_sat;
            endcase
            hdr_idx <= hdr_idx + 2'd1;
            if (hdr_idx == 2'd2) begin
              state <= in_empty ? S_IDLE : S_REP_RD;
            end
          end
        end
        S_REP_RD: begin
          rep_last <= (in_total == (CW + 1)'(1));
          state    <= S_REP_DATA;
        end
        S_REP_DATA: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_kind   <= dfb_pkg::KIND_REPORT;
            out_report <= mem_rd_data;
            out_last   <= rep_last;
            state      <= rep_last ? S_IDLE : S_REP_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/dual_fifo_serial_frame_bridge.sv @@
// Top level of the dual FIFO serial frame bridge: sequencer and queue memory.
// A push, gpio write, held or refused operation loads its result from the execute state,
// a frame from the second frame state; the next item is taken in the cycle after the
// result is loaded. Report: three header bytes one per cycle while the output is free,
// then each drained byte through the single memory read port (one read, one register stage).
// Reset empties all queues, clears the output gpio and sets the input gpio to 0xAA;
// the memory contents are not cleared.
module dual_fifo_serial_frame_bridge #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  dfb_req_if.sink   req,
  dfb_rsp_if.source rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH) + 2;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;

  dfb_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  dfb_mem #(
    .AW(AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of the dual FIFO serial frame bridge.
`timescale 1ns / 1ps

module tb_top;
  import dfb_pkg::*;

  localparam int FIFO_DEPTH     = 16;
  localparam int RANDOM_ITEMS   = 150;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int QUIET_LIMIT    = 3000;
  localparam int TAIL_CYCLES    = 20;
  localparam int DIRECTED_ROWS  = 25;

  typedef struct packed {
    op_t        op;
    logic       channel;
    logic [7:0] data;
    logic [7:0] rx_status;
    logic [7:0] rx_chan0;
    logic [7:0] rx_chan1;
    logic       hold;
  } req_item_t;

  typedef struct packed {
    kind_t      kind;
    logic       accepted;
    logic [7:0] tx_status;
    logic [7:0] tx_chan0;
    logic [7:0] tx_chan1;
    logic [7:0] report_byte;
    logic       last;
  } bridge_result_t;

  typedef struct packed {
    op_t        op;
    logic       channel;
    logic [7:0] data;
    logic [7:0] rx_status;
    logic [7:0] rx_chan0;
    logic [7:0] rx_chan1;
    logic       hold;
    logic [4:0] reps;
    logic       typed;
    kind_t      kind;
    logic       accepted;
    logic [7:0] tx_status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dfb_req_if req_bus ();
  dfb_rsp_if rsp_bus ();

  dual_fifo_serial_frame_bridge #(.QUEUE_DEPTH(FIFO_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #5 clk = ~clk;

  logic [7:0]     outbound_ch0[$];
  logic [7:0]     outbound_ch1[$];
  logic [7:0]     inbound_ch0[$];
  logic [7:0]     inbound_ch1[$];
  logic [5:0]     gpio_tx_model;
  logic [7:0]     gpio_in_model;
  bridge_result_t step_results[$];
  bridge_result_t pending_results[$];
  stim_row_t      directed_rows [DIRECTED_ROWS];

  int   mismatches = 0;
  int   holdoff_requests = 0;
  logic calm = 1'b0;

  function automatic logic [7:0] clamp_count(input int unsigned n);
    return (n > 255) ? 8'hFF : n[7:0];
  endfunction

  function automatic void step_bridge(input req_item_t it);
    bridge_result_t r;
    logic [7:0]     stream[$];
    step_results.delete();
    r = '0;
    r.kind = KIND_ACK;
    r.last = 1'b1;
    if (it.op == OP_PUSH) begin
      if (it.channel && outbound_ch1.size() < FIFO_DEPTH) begin
        outbound_ch1.push_back(it.data);
        r.accepted = 1'b1;
      end else if (!it.channel && outbound_ch0.size() < FIFO_DEPTH) begin
        outbound_ch0.push_back(it.data);
        r.accepted = 1'b1;
      end
      step_results.push_back(r);
    end else if (it.op == OP_GPIO) begin
      gpio_tx_model = it.data[5:0];
      r.accepted = 1'b1;
      step_results.push_back(r);
    end else if (it.hold) begin
      r.kind = KIND_NONE;
      step_results.push_back(r);
    end else if (it.op == OP_FRAME) begin
      if (inbound_ch0.size() >= FIFO_DEPTH || inbound_ch1.size() >= FIFO_DEPTH) begin
        r.kind = KIND_NONE;
      end else begin
        r.kind = KIND_FRAME;
        r.tx_status = {gpio_tx_model, 2'b00};
        if (outbound_ch0.size() != 0) begin
          r.tx_chan0 = outbound_ch0.pop_front();
          r.tx_status[0] = 1'b1;
        end
        if (outbound_ch1.size() != 0) begin
          r.tx_chan1 = outbound_ch1.pop_front();
          r.tx_status[1] = 1'b1;
        end
        gpio_in_model = {2'b00, it.rx_status[7:2]};
        if (it.rx_status[0]) inbound_ch0.push_back(it.rx_chan0);
        if (it.rx_status[1]) inbound_ch1.push_back(it.rx_chan1);
      end
      step_results.push_back(r);
    end else begin
      stream.push_back(gpio_in_model);
      stream.push_back(clamp_count(inbound_ch0.size()));
      stream.push_back(clamp_count(inbound_ch1.size()));
      foreach (inbound_ch0[i]) stream.push_back(inbound_ch0[i]);
      foreach (inbound_ch1[i]) stream.push_back(inbound_ch1[i]);
      inbound_ch0.delete();
      inbound_ch1.delete();
      r.kind = KIND_REPORT;
      foreach (stream[i]) begin
        r.report_byte = stream[i];
        r.last = (i == stream.size() - 1);
        step_results.push_back(r);
      end
    end
  endfunction

  task automatic send_item(input req_item_t it, input logic typed, input bridge_result_t want);
    req_bus.valid     <= 1'b1;
    req_bus.operation <= it.op;
    req_bus.channel   <= it.channel;
    req_bus.data      <= it.data;
    req_bus.rx_status <= it.rx_status;
    req_bus.rx_chan0  <= it.rx_chan0;
    req_bus.rx_chan1  <= it.rx_chan1;
    req_bus.hold      <= it.hold;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    step_bridge(it);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    if (!calm && $urandom_range(99) < 20) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic req_item_t random_item(input op_t op);
    req_item_t it;
    it.op        = op;
    it.channel   = 1'($urandom_range(1));
    it.data      = 8'($urandom_range(255));
    it.rx_status = 8'($urandom_range(255));
    it.rx_chan0  = 8'($urandom_range(255));
    it.rx_chan1  = 8'($urandom_range(255));
    it.hold      = ($urandom_range(99) < 6);
    return it;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    bridge_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: kind %0d, report_byte 0x%0h",
               rsp_bus.kind, rsp_bus.report_byte);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, rsp_bus.kind);
        check_field("accepted", want.accepted, rsp_bus.accepted);
        check_field("tx_status", want.tx_status, rsp_bus.tx_status);
        check_field("tx_chan0", want.tx_chan0, rsp_bus.tx_chan0);
        check_field("tx_chan1", want.tx_chan1, rsp_bus.tx_chan1);
        check_field("report_byte", want.report_byte, rsp_bus.report_byte);
        check_field("last", want.last, rsp_bus.last);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : receiver
    int holdoff_served;
    holdoff_served = 0;
    rsp_bus.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (holdoff_served != holdoff_requests) begin
        holdoff_served++;
        rsp_bus.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else begin
        rsp_bus.ready <= calm || ($urandom_range(99) >= 20);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    req_item_t      it;
    bridge_result_t want;
    stim_row_t      row;
    int             counted;
    int             burst;
    int             pick;
    logic           holdoff_sent;
    logic           paused;

    req_bus.valid     <= 1'b0;
    req_bus.operation <= OP_PUSH;
    req_bus.channel   <= 1'b0;
    req_bus.data      <= 8'h00;
    req_bus.rx_status <= 8'h00;
    req_bus.rx_chan0  <= 8'h00;
    req_bus.rx_chan1  <= 8'h00;
    req_bus.hold      <= 1'b0;

    outbound_ch0.delete();
    outbound_ch1.delete();
    inbound_ch0.delete();
    inbound_ch1.delete();
    gpio_tx_model = 6'd0;
    gpio_in_model = GPIO_IN_RESET;

    // op, channel, data, rx_status, rx_chan0, rx_chan1, hold, reps,
    // typed, kind, accepted, tx_status
    directed_rows = '{
      '{OP_REPORT, 0, 'h00, 'h00, 'h00, 'h00, 0,  1, 0, KIND_ACK,   0, 'h00},
      '{OP_FRAME,  0, 'h00, 'hFF, 'hFF, 'hFF, 1,  1, 1, KIND_NONE,  0, 'h00},
      '{OP_REPORT, 1, 'hFF, 'h00, 'h00, 'h00, 1,  1, 1, KIND_NONE,  0, 'h00},
      '{OP_PUSH,   0, 'h00, 'hFF, 'hFF, 'hFF, 1,  1, 1, KIND_ACK,   1, 'h00},
      '{OP_GPIO,   0, 'hFF, 'h00, 'h00, 'h00, 0,  1, 1, KIND_ACK,   1, 'h00},
      '{OP_PUSH,   1, 'hFF, 'h00, 'h00, 'h00, 0,  1, 1, KIND_ACK,   1, 'h00},
      '{OP_FRAME,  0, 'h00, 'hFF, 'h00, 'hFF, 0,  1, 0, KIND_ACK,   0, 'h00},
      '{OP_GPIO,   1, 'hC0, 'h00, 'h00, 'h00, 0,  1, 1, KIND_ACK,   1, 'h00},
      '{OP_FRAME,  1, 'hFF, 'h00, 'hFF, 'hFF, 0,  1, 1, KIND_FRAME, 0, 'h00},
      '{OP_REPORT, 0, 'h00, 'h00, 'h00, 'h00, 0,  1, 0, KIND_ACK,   0, 'h00},
      '{OP_PUSH,   0, 'h00, 'h00, 'h00, 'h00, 0, 16, 0, KIND_ACK,   0, 'h00},
      '{OP_PUSH,   0, 'h5A, 'h00, 'h00, 'h00, 0,  1, 1, KIND_ACK,   0, 'h00},
      '{OP_PUSH,   1, 'h00, 'h00, 'h00, 'h00, 0, 16, 0, KIND_ACK,   0, 'h00},
      '{OP_PUSH,   1, 'hA5, 'h00, 'h00, 'h00, 0,  1, 1, KIND_ACK,   0, 'h00},
      '{OP_GPIO,   0, 'h2A, 'h00, 'h00, 'h00, 0,  1, 1, KIND_ACK,   1, 'h00},
      '{OP_FRAME,  0, 'h00, 'h03, 'h00, 'h00, 0, 16, 0, KIND_ACK,   0, 'h00},
      '{OP_FRAME,  0, 'h00, 'h03, 'h11, 'h22, 0,  1, 1, KIND_NONE,  0, 'h00},
      '{OP_REPORT, 0, 'h00, 'h00, 'h00, 'h00, 0,  1, 0, KIND_ACK,   0, 'h00},
      '{OP_FRAME,  0, 'h00, 'h01, 'h00, 'h00, 0, 16, 0, KIND_ACK,   0, 'h00},
      '{OP_FRAME,  0, 'h00, 'h02, 'h33, 'h44, 0,  1, 1, KIND_NONE,  0, 'h00},
      '{OP_REPORT, 0, 'h00, 'h00, 'h00, 'h00, 0,  1, 0, KIND_ACK,   0, 'h00},
      '{OP_FRAME,  0, 'h00, 'h02, 'h00, 'h00, 0, 16, 0, KIND_ACK,   0, 'h00},
      '{OP_FRAME,  0, 'h00, 'h01, 'h55, 'h66, 0,  1, 1, KIND_NONE,  0, 'h00},
      '{OP_FRAME,  0, 'h00, 'h00, 'h00, 'h00, 1,  1, 1, KIND_NONE,  0, 'h00},
      '{OP_REPORT, 0, 'h00, 'h00, 'h00, 'h00, 0,  1, 0, KIND_ACK,   0, 'h00}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Repeated rows get fresh payload bytes and partner gpio on every item.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        it.op        = row.op;
        it.channel   = row.channel;
        it.data      = row.data;
        it.rx_status = row.rx_status;
        it.rx_chan0  = row.rx_chan0;
        it.rx_chan1  = row.rx_chan1;
        it.hold      = row.hold;
        if (row.reps > 1) begin
          it.data           = 8'($urandom_range(255));
          it.rx_chan0       = 8'($urandom_range(255));
          it.rx_chan1       = 8'($urandom_range(255));
          it.rx_status[7:2] = 6'($urandom_range(63));
        end
        want           = '0;
        want.kind      = row.kind;
        want.accepted  = row.accepted;
        want.tx_status = row.tx_status;
        want.last      = 1'b1;
        send_item(it, row.typed, want);
      end
    end

    req_bus.valid <= 1'b0;
    wait_drained();

    counted      = 0;
    holdoff_sent = 1'b0;
    paused       = 1'b0;
    want         = '0;
    while (counted < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 60);
      for (int k = 0; k <= burst && counted < RANDOM_ITEMS; k++) begin
        if (counted >= 40 && !holdoff_sent) begin
          holdoff_requests++;
          holdoff_sent = 1'b1;
        end
        if (counted >= 120 && !paused) begin
          req_bus.valid <= 1'b0;
          wait_drained();
          paused = 1'b1;
        end
        calm = (counted >= 70 && counted < 110);
        pick = $urandom_range(99);
        if (k == burst) begin
          it = random_item(OP_REPORT);
        end else if (pick < 35) begin
          it = random_item(OP_PUSH);
        end else if (pick < 45) begin
          it = random_item(OP_GPIO);
        end else begin
          it = random_item(OP_FRAME);
        end
        send_item(it, 1'b0, want);
        if (!(it.hold && (it.op == OP_FRAME || it.op == OP_REPORT))) counted++;
      end
    end

    calm = 1'b0;
    req_bus.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
